FILE: rtl/dap_pkg.sv
// Shared types and constants for the diffuse/ambient pixel shader.
// Used by every shader module under rtl (not by dap_checker); no dependencies.
package dap_pkg;

   localparam int CH_BITS   = 16;
   localparam int CH_ONE    = 1 << (CH_BITS - 1);
   localparam int AMB_RESET = (CH_ONE + 5) / 10;

   // normal and light components are fixed at 16 bits
   localparam int VEC_BITS  = 16;
   localparam int SQ_BITS   = 50;    // root work registers (q << 16 is 48 bits)
   localparam int SQ_STEPS  = 24;    // one result bit per step
   localparam int LEN_BITS  = 24;
   localparam int DVD_BITS  = 40;    // s << 8, s below 2^32 when positive
   localparam int REM_BITS  = 42;
   localparam int QUO_BITS  = 18;    // cosine stays below 2^17
   localparam int DIV_STEPS = QUO_BITS;
   localparam int STEP_BITS = 5;

   localparam logic [15:0] LIGHT_X_RESET = 16'd13377;
   localparam logic [15:0] LIGHT_Y_RESET = 16'd13377;
   localparam logic [15:0] LIGHT_Z_RESET = 16'd26755;

   typedef enum logic [1:0] {
      REG_LIGHT_X = 2'd0,
      REG_LIGHT_Y = 2'd1,
      REG_LIGHT_Z = 2'd2,
      REG_AMBIENT = 2'd3
   } reg_index_type;

   // per-pixel payload that rides along the cell chain
   typedef struct packed {
      logic [CH_BITS-1:0]  red;
      logic [CH_BITS-1:0]  green;
      logic [CH_BITS-1:0]  blue;
      logic [CH_BITS-1:0]  metal;   // already saturated to one
      logic [DVD_BITS-1:0] dvd;
      logic                lit;     // s > 0 and normal nonzero
   } pix_type;

   typedef struct packed {
      logic [SQ_BITS-1:0] v;
      logic [SQ_BITS-1:0] res;
   } sq_type;

   typedef struct packed {
      logic [REM_BITS-1:0] rem;
      logic [QUO_BITS-1:0] quo;
      logic [LEN_BITS-1:0] len;
   } dv_type;

endpackage

FILE: rtl/diffuse_ambient_pixel_shade.sv
// Top level of the Lambert diffuse + ambient pixel shader.
// Depends on dap_pkg, dap_sqrt_cell, dap_div_cell.
//
// Usage:
//   req_* carries one pixel: base color, metallic weight and a raw normal.
//   rsp_* returns the shaded color with alpha fixed at one.
//   A request is taken when req_valid is high and req_stall low; a result
//   leaves when rsp_valid is high and rsp_stall low.
//   csr_* writes light_x/y/z and ambient_level; write only while idle.
// Pipeline:
//   input reg -> dot/norm products -> 24 root cells -> 18 divide cells
//   -> diffuse factor -> channel multiply and clamp (output reg).
//   One pixel per cycle sustained while no result is held by rsp_stall;
//   each root and divide cell performs one step.
// Stall:
//   When a result is held by rsp_stall the whole chain freezes and
//   req_stall is raised in the same cycle; nothing is dropped.
// Reset:
//   Synchronous, active high. Clears all valid bits and restores the
//   light direction and ambient registers to their defaults.
module diffuse_ambient_pixel_shade (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_base_red,
   input  logic [15:0] req_base_green,
   input  logic [15:0] req_base_blue,
   input  logic [15:0] req_metal_weight,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_shade_red,
   output logic [15:0] rsp_shade_green,
   output logic [15:0] rsp_shade_blue,
   output logic [15:0] rsp_shade_alpha,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import dap_pkg::*;

   logic en;

   // configuration registers
   logic signed [15:0] light_x_ff, light_y_ff, light_z_ff;
   logic [CH_BITS-1:0] ambient_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff <= LIGHT_X_RESET;
         light_y_ff <= LIGHT_Y_RESET;
         light_z_ff <= LIGHT_Z_RESET;
         ambient_ff <= CH_BITS'(AMB_RESET);
      end else if (csr_wr_en) begin
         unique case (reg_index_type'(csr_index))
            REG_LIGHT_X: light_x_ff <= csr_data;
            REG_LIGHT_Y: light_y_ff <= csr_data;
            REG_LIGHT_Z: light_z_ff <= csr_data;
            REG_AMBIENT: ambient_ff <= csr_data[CH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // whole chain advances unless a finished result is held
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // stage A: input register, metal saturated
   logic               a_valid_ff;
   logic [CH_BITS-1:0] a_red_ff, a_green_ff, a_blue_ff, a_metal_ff;
   logic signed [15:0] a_nx_ff, a_ny_ff, a_nz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_red_ff   <= req_base_red;
         a_green_ff <= req_base_green;
         a_blue_ff  <= req_base_blue;
         a_metal_ff <= (req_metal_weight > CH_BITS'(CH_ONE)) ? CH_BITS'(CH_ONE)
                                                             : req_metal_weight;
         a_nx_ff    <= req_normal_x;
         a_ny_ff    <= req_normal_y;
         a_nz_ff    <= req_normal_z;
      end
   end

   // stage B: dot product with light and squared length
   logic signed [32:0] s_w;
   logic [31:0]        q_w;
   logic               b_valid_ff;
   pix_type            b_pix_ff, b_pix_in;
   sq_type             b_sq_ff, b_sq_in;

   always_comb begin
      s_w = 33'(a_nx_ff * light_x_ff) + 33'(a_ny_ff * light_y_ff)
          + 33'(a_nz_ff * light_z_ff);
      q_w = 32'(a_nx_ff * a_nx_ff) + 32'(a_ny_ff * a_ny_ff) + 32'(a_nz_ff * a_nz_ff);
      b_pix_in.red   = a_red_ff;
      b_pix_in.green = a_green_ff;
      b_pix_in.blue  = a_blue_ff;
      b_pix_in.metal = a_metal_ff;
      b_pix_in.dvd   = {s_w[31:0], 8'd0};
      b_pix_in.lit   = (s_w > 33'sd0) && (q_w != 32'd0);
      b_sq_in.v      = {2'd0, q_w, 16'd0};
      b_sq_in.res    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_pix_ff <= b_pix_in;
         b_sq_ff  <= b_sq_in;
      end
   end

   // root chain
   logic    sq_valid [SQ_STEPS+1];
   pix_type sq_pix   [SQ_STEPS+1];
   sq_type  sq_st    [SQ_STEPS+1];

   assign sq_valid[0] = b_valid_ff;
   assign sq_pix[0]   = b_pix_ff;
   assign sq_st[0]    = b_sq_ff;

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
      dap_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .step      (STEP_BITS'(i)),
         .in_valid  (sq_valid[i]),
         .in_pix    (sq_pix[i]),
         .in_sq     (sq_st[i]),
         .out_valid (sq_valid[i+1]),
         .out_pix   (sq_pix[i+1]),
         .out_sq    (sq_st[i+1])
      );
   end

   // divide chain
   logic    dv_valid [DIV_STEPS+1];
   pix_type dv_pix   [DIV_STEPS+1];
   dv_type  dv_st    [DIV_STEPS+1];

   assign dv_valid[0]  = sq_valid[SQ_STEPS];
   assign dv_pix[0]    = sq_pix[SQ_STEPS];
   assign dv_st[0].rem = REM_BITS'(sq_pix[SQ_STEPS].dvd);
   assign dv_st[0].quo = '0;
   assign dv_st[0].len = sq_st[SQ_STEPS].res[LEN_BITS-1:0];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      dap_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .step      (STEP_BITS'(i)),
         .in_valid  (dv_valid[i]),
         .in_pix    (dv_pix[i]),
         .in_dv     (dv_st[i]),
         .out_valid (dv_valid[i+1]),
         .out_pix   (dv_pix[i+1]),
         .out_dv    (dv_st[i+1])
      );
   end

   // factor stage
   logic [QUO_BITS-1:0]         cosine_w;
   logic [QUO_BITS+CH_BITS-1:0] diff_w;
   logic [CH_BITS+3:0]          f_factor_ff, f_factor_in;
   logic                        f_valid_ff;
   logic [CH_BITS-1:0]          f_red_ff, f_green_ff, f_blue_ff;

   always_comb begin
      cosine_w    = dv_pix[DIV_STEPS].lit ? dv_st[DIV_STEPS].quo : '0;
      diff_w      = cosine_w * (CH_BITS'(CH_ONE) - dv_pix[DIV_STEPS].metal);
      f_factor_in = (CH_BITS+4)'(diff_w >> (CH_BITS - 1)) + (CH_BITS+4)'(ambient_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= dv_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_factor_ff <= f_factor_in;
         f_red_ff    <= dv_pix[DIV_STEPS].red;
         f_green_ff  <= dv_pix[DIV_STEPS].green;
         f_blue_ff   <= dv_pix[DIV_STEPS].blue;
      end
   end

   // channel multiply and clamp into output register
   function automatic logic [CH_BITS-1:0] shade(input logic [CH_BITS-1:0] b,
                                                input logic [CH_BITS+3:0] f);
      logic [2*CH_BITS+3:0] p;
      logic [CH_BITS+4:0]   c;
      p = b * f;
      c = (CH_BITS+5)'(p >> (CH_BITS - 1));
      return (c > (CH_BITS+5)'(CH_ONE)) ? CH_BITS'(CH_ONE) : c[CH_BITS-1:0];
   endfunction

   logic               o_valid_ff;
   logic [CH_BITS-1:0] o_red_ff, o_green_ff, o_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (en) begin
         o_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_red_ff   <= shade(f_red_ff, f_factor_ff);
         o_green_ff <= shade(f_green_ff, f_factor_ff);
         o_blue_ff  <= shade(f_blue_ff, f_factor_ff);
      end
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_shade_red   = o_red_ff;
   assign rsp_shade_green = o_green_ff;
   assign rsp_shade_blue  = o_blue_ff;
   assign rsp_shade_alpha = CH_BITS'(CH_ONE);
endmodule

FILE: rtl/dap_sqrt_cell.sv
// One step of the bit-pair integer square root; registered.
// Depends on dap_pkg.
module dap_sqrt_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic [dap_pkg::STEP_BITS-1:0] step,
   input  logic                     in_valid,
   input  dap_pkg::pix_type         in_pix,
   input  dap_pkg::sq_type          in_sq,
   output logic                     out_valid,
   output dap_pkg::pix_type         out_pix,
   output dap_pkg::sq_type          out_sq
);
   import dap_pkg::*;

   logic               valid_ff;
   pix_type            pix_ff;
   sq_type             sq_ff, sq_in;
   logic [SQ_BITS-1:0] bit_w, trial;

   always_comb begin
      bit_w = SQ_BITS'(1) << (2 * (SQ_STEPS - 1 - int'(step)));
      trial = in_sq.res + bit_w;
      if (in_sq.v >= trial) begin
         sq_in.v   = in_sq.v - trial;
         sq_in.res = (in_sq.res >> 1) + bit_w;
      end else begin
         sq_in.v   = in_sq.v;
         sq_in.res = in_sq.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pix_ff <= in_pix;
         sq_ff  <= sq_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pix   = pix_ff;
   assign out_sq    = sq_ff;
endmodule

FILE: rtl/dap_div_cell.sv
// One restoring-division step: one quotient bit per cell; registered.
// Depends on dap_pkg.
module dap_div_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic [dap_pkg::STEP_BITS-1:0] step,
   input  logic                     in_valid,
   input  dap_pkg::pix_type         in_pix,
   input  dap_pkg::dv_type          in_dv,
   output logic                     out_valid,
   output dap_pkg::pix_type         out_pix,
   output dap_pkg::dv_type          out_dv
);
   import dap_pkg::*;

   logic                valid_ff;
   pix_type             pix_ff;
   dv_type              dv_ff, dv_in;
   logic [REM_BITS-1:0] shifted;
   int                  pos;

   always_comb begin
      pos     = QUO_BITS - 1 - int'(step);
      shifted = REM_BITS'(in_dv.len) << pos;
      dv_in   = in_dv;
      if (in_dv.rem >= shifted) begin
         dv_in.rem = in_dv.rem - shifted;
         dv_in.quo = in_dv.quo | (QUO_BITS'(1) << pos);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pix_ff <= in_pix;
         dv_ff  <= dv_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pix   = pix_ff;
   assign out_dv    = dv_ff;
endmodule

FILE: rtl/dap_checker.sv
// Port-level checks for the pixel shader, bound to the top level.
// Depends on diffuse_ambient_pixel_shade ports only.
module dap_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_shade_red,
   input logic [15:0] rsp_shade_green,
   input logic [15:0] rsp_shade_blue,
   input logic [15:0] rsp_shade_alpha
);
   a_alpha_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_shade_alpha == 16'd32768)
      else $error("alpha not one");

   a_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_shade_red <= 16'd32768) && (rsp_shade_green <= 16'd32768)
                    && (rsp_shade_blue <= 16'd32768))
      else $error("channel above one");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while result held");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_shade_red))
      else $error("held result changed");
endmodule

bind diffuse_ambient_pixel_shade dap_checker u_dap_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_shade_red   (rsp_shade_red),
   .rsp_shade_green (rsp_shade_green),
   .rsp_shade_blue  (rsp_shade_blue),
   .rsp_shade_alpha (rsp_shade_alpha)
);
